// File: design/lpvc_pkg.sv
// ----------------------------------------------------------------------------
// lpvc_pkg
// Shared types and constants for the length-prefix size codec: the item
// and result structs, the internal command carried from front to back.
// ----------------------------------------------------------------------------
package lpvc_pkg;

    // operation codes carried in the mode field
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // prefix bytes
    localparam logic [7:0] PFX_ONE   = 8'd251;
    localparam logic [7:0] PFX_TWO   = 8'd252;
    localparam logic [7:0] PFX_FOUR  = 8'd253;
    localparam logic [7:0] PFX_EIGHT = 8'd254;
    localparam logic [7:0] PFX_ALT   = 8'd255;

    // value bounds and offset
    localparam logic [63:0] LIM_DIRECT = 64'd250;
    localparam logic [63:0] LIM_ONE    = 64'hFF + 64'd250;
    localparam logic [63:0] LIM_TWO    = 64'hFFFF + 64'd250;
    localparam logic [63:0] LIM_FOUR   = 64'hFFFF_FFFF;
    localparam logic [16:0] OFFSET     = 17'd250;

    // payload lengths
    localparam logic [3:0] LEN_NONE  = 4'd0;
    localparam logic [3:0] LEN_ONE   = 4'd1;
    localparam logic [3:0] LEN_TWO   = 4'd2;
    localparam logic [3:0] LEN_FOUR  = 4'd4;
    localparam logic [3:0] LEN_EIGHT = 4'd8;

    // default depth of the command queue
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic        mode;
        logic [63:0] value;
        logic [7:0]  byte_in;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic [63:0] decoded_value;
        logic        value_done;
        logic        last;
    } result_t;

    // one classified command: an encode run or a single decode result
    typedef struct packed {
        logic        is_dec;
        logic        done;
        logic [7:0]  head;
        logic [3:0]  len;
        logic [63:0] data;
    } cmd_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_status_t;

endpackage

// File: design/lpvc_front.sv
// ----------------------------------------------------------------------------
// lpvc_front
// Accepts items, classifies encode values by size and runs the decoder
// state, producing one command per item for the queue.
// ----------------------------------------------------------------------------
module lpvc_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  lpvc_pkg::item_t   item,
    output lpvc_pkg::cmd_t    cmd
);

    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic        add_offset_reg, add_offset_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  pos_reg, pos_next;

    lpvc_pkg::cmd_t enc_cmd;
    lpvc_pkg::cmd_t dec_cmd;
    logic [16:0]    small_sub;
    logic [63:0]    acc_merged;
    logic [3:0]     left_dec;

    // encode classification
    always_comb
    begin
        small_sub      = item.value[16:0] - lpvc_pkg::OFFSET;
        enc_cmd        = '0;
        enc_cmd.is_dec = 1'b0;
        if (item.value > lpvc_pkg::LIM_FOUR)
        begin
            enc_cmd.head = lpvc_pkg::PFX_EIGHT;
            enc_cmd.data = item.value;
            enc_cmd.len  = lpvc_pkg::LEN_EIGHT;
        end
        else if (item.value > lpvc_pkg::LIM_TWO)
        begin
            enc_cmd.head = lpvc_pkg::PFX_FOUR;
            enc_cmd.data = item.value;
            enc_cmd.len  = lpvc_pkg::LEN_FOUR;
        end
        else if (item.value > lpvc_pkg::LIM_ONE)
        begin
            enc_cmd.head = lpvc_pkg::PFX_TWO;
            enc_cmd.data = {48'd0, small_sub[15:0]};
            enc_cmd.len  = lpvc_pkg::LEN_TWO;
        end
        else if (item.value > lpvc_pkg::LIM_DIRECT)
        begin
            enc_cmd.head = lpvc_pkg::PFX_ONE;
            enc_cmd.data = {48'd0, small_sub[15:0]};
            enc_cmd.len  = lpvc_pkg::LEN_ONE;
        end
        else
        begin
            enc_cmd.head = item.value[7:0];
            enc_cmd.data = '0;
            enc_cmd.len  = lpvc_pkg::LEN_NONE;
        end
    end

    // decoder step
    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        add_offset_next = add_offset_reg;
        acc_next        = acc_reg;
        pos_next        = pos_reg;
        dec_cmd         = '0;
        dec_cmd.is_dec  = 1'b1;
        acc_merged      = acc_reg | ({56'd0, item.byte_in} << {pos_reg, 3'b000});
        left_dec        = bytes_left_reg - 4'd1;
        if (bytes_left_reg == lpvc_pkg::LEN_NONE)
        begin
            acc_next        = '0;
            pos_next        = '0;
            add_offset_next = 1'b0;
            case (item.byte_in)
                lpvc_pkg::PFX_EIGHT,
                lpvc_pkg::PFX_ALT:   bytes_left_next = lpvc_pkg::LEN_EIGHT;
                lpvc_pkg::PFX_FOUR:  bytes_left_next = lpvc_pkg::LEN_FOUR;
                lpvc_pkg::PFX_TWO:
                begin
                    bytes_left_next = lpvc_pkg::LEN_TWO;
                    add_offset_next = 1'b1;
                end
                lpvc_pkg::PFX_ONE:
                begin
                    bytes_left_next = lpvc_pkg::LEN_ONE;
                    add_offset_next = 1'b1;
                end
                default:
                begin
                    dec_cmd.done = 1'b1;
                    dec_cmd.data = {56'd0, item.byte_in};
                end
            endcase
        end
        else
        begin
            bytes_left_next = left_dec;
            if (left_dec == lpvc_pkg::LEN_NONE)
            begin
                // final payload byte, value complete
                dec_cmd.done    = 1'b1;
                dec_cmd.data    = acc_merged
                                + (add_offset_reg ? {47'd0, lpvc_pkg::OFFSET} : 64'd0);
                acc_next        = '0;
                pos_next        = '0;
                add_offset_next = 1'b0;
            end
            else
            begin
                acc_next = acc_merged;
                pos_next = pos_reg + 3'd1;
            end
        end
    end

    // command for the queue
    assign cmd = (item.mode == lpvc_pkg::MODE_DECODE) ? dec_cmd : enc_cmd;

    // decoder state, held across encode items
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            add_offset_reg <= 1'b0;
            acc_reg        <= '0;
            pos_reg        <= '0;
        end
        else if (accept && item.mode == lpvc_pkg::MODE_DECODE)
        begin
            bytes_left_reg <= bytes_left_next;
            add_offset_reg <= add_offset_next;
            acc_reg        <= acc_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

// File: design/lpvc_queue.sv
// ----------------------------------------------------------------------------
// lpvc_queue
// Short command queue between front and back, so each side can stall
// on its own.
// ----------------------------------------------------------------------------
module lpvc_queue
#(
    parameter int DEPTH = lpvc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  lpvc_pkg::cmd_t       wr_cmd,
    input  logic                 rd_en,
    output logic                 full,
    output lpvc_pkg::q_status_t  status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    lpvc_pkg::cmd_t  slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full         = (count_reg == FULL_CNT);
    assign status.valid = (count_reg != '0);
    assign status.cmd   = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // command storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: design/lpvc_back.sv
// ----------------------------------------------------------------------------
// lpvc_back
// Carries out queued commands into the output register: an encode run one
// byte per cycle while the output is free or popped, or a decode result.
// ----------------------------------------------------------------------------
module lpvc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lpvc_pkg::q_status_t  q,
    output logic                 q_pop,
    input  logic                 pop,
    output logic                 empty,
    output lpvc_pkg::result_t    result
);

    logic [3:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    lpvc_pkg::result_t   result_reg, result_next;
    logic                advance;
    logic [2:0]          byte_idx;
    logic                at_end;

    assign empty   = !out_valid_reg;
    assign result  = result_reg;
    assign advance = q.valid && (!out_valid_reg || pop);
    assign byte_idx = 3'(cnt_reg - 4'd1);
    assign at_end  = q.cmd.is_dec || (cnt_reg == q.cmd.len);
    assign q_pop   = advance && at_end;

    // next result and byte counter
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            result_next    = '0;
            if (q.cmd.is_dec)
            begin
                result_next.decoded_value = q.cmd.data;
                result_next.value_done    = q.cmd.done;
            end
            else
            begin
                result_next.byte_valid = 1'b1;
                result_next.out_byte   = (cnt_reg == '0) ? q.cmd.head
                                       : q.cmd.data[{byte_idx, 3'b000} +: 8];
            end
            result_next.last = at_end;
            cnt_next         = at_end ? '0 : cnt_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // a run in progress always has its command at the queue head
    a_cnt_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) |-> q.valid)
        else $error("byte counter running with no queued command");

    // decode commands never start a multi-byte run
    a_dec_single: assert property (@(posedge clk) disable iff (!rst_n)
        (q.valid && q.cmd.is_dec) |-> (cnt_reg == '0))
        else $error("decode command met mid-run");

    // counter stays within the run length
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (q.valid && !q.cmd.is_dec) |-> (cnt_reg <= q.cmd.len))
        else $error("byte counter past run length");
`endif

endmodule

// File: design/length_prefix_varint_codec_top.sv
// ----------------------------------------------------------------------------
// length_prefix_varint_codec_top
// Size codec with a 250 offset: encodes a 64-bit size into 1 to 9 bytes,
// or decodes one byte of such a stream per item.
//
//   channel   signals            direction   transfer when
//   item      push, full, item   in          push && !full
//   result    empty, pop, result out         pop && !empty
//
// A decode item gives one result, an encode item gives 1 + payload bytes
// results, one per cycle from the back end while the output is free or
// popped. The front end takes one item per cycle while the command queue
// has room; the queue depth sets how far it runs ahead of a long encode
// run. Each result is registered from the command at the queue head. Reset
// clears the decoder state and empties the queue and the output register.
// ----------------------------------------------------------------------------
module length_prefix_varint_codec_top
#(
    parameter int QUEUE_DEPTH = lpvc_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lpvc_pkg::item_t     item,
    output logic                empty,
    input  logic                pop,
    output lpvc_pkg::result_t   result
);

    logic                 accept;
    lpvc_pkg::cmd_t       cmd;
    lpvc_pkg::q_status_t  q_status;
    logic                 q_pop;

    assign accept = push && !full;

    // classify and decode
    lpvc_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (cmd)
    );

    // command queue
    lpvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (cmd),
        .rd_en  (q_pop),
        .full   (full),
        .status (q_status)
    );

    // byte emission and output register
    lpvc_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .q      (q_status),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

endmodule
